>>> hdl/tgpb_pkg.sv
// Shared types, register codes and key-layout tables for the glide pitch-bend unit.
package tgpb_pkg;

  localparam int unsigned MODE_BITS  = 2;
  localparam int unsigned RANGE_BITS = 6;
  localparam int unsigned W_BITS     = 10;
  localparam int unsigned BEND_BITS  = 14;
  localparam int unsigned IDX_BITS   = 2;

  // Register indexes of the configuration port.
  localparam logic [IDX_BITS-1:0] REG_BEND_MODE   = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_BEND_RANGE  = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_WHITE_WIDTH = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_LEFT_X      = 2'd3;

  // Bend modes; any other code behaves as the key-center map.
  localparam logic [MODE_BITS-1:0] MODE_KEY   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_SEMI  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_WHOLE = 2'd2;

  localparam logic [BEND_BITS-1:0] BEND_CENTRE = 14'h2000;
  localparam logic [BEND_BITS-1:0] BEND_MAX    = 14'h3FFF;

  // Static settings that the key-map stages need.
  typedef struct packed {
    logic              key_mode;
    logic              wzero;
    logic [W_BITS-1:0] weff;
  } map_cfg_t;

  // Key centers in half-white-key units, one entry per semitone of an octave.
  function automatic logic [3:0] key_centre(input logic [3:0] s);
    logic [3:0] c;
    case (s)
      4'd0:    c = 4'd1;
      4'd1:    c = 4'd2;
      4'd2:    c = 4'd3;
      4'd3:    c = 4'd4;
      4'd4:    c = 4'd5;
      4'd5:    c = 4'd7;
      4'd6:    c = 4'd8;
      4'd7:    c = 4'd9;
      4'd8:    c = 4'd10;
      4'd9:    c = 4'd11;
      4'd10:   c = 4'd12;
      4'd11:   c = 4'd13;
      default: c = 4'd15;
    endcase
    return c;
  endfunction

  // A segment is steep when its two centers lie one half-key apart.
  function automatic logic seg_steep(input logic [3:0] s);
    return !(s == 4'd4 || s == 4'd11);
  endfunction

endpackage

>>> hdl/tgpb_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband data.
module tgpb_div #(
  parameter int unsigned NW  = 16,
  parameter int unsigned DW  = 8,
  parameter int unsigned SBW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DW-1:0]  den_i,
  input  logic [SBW-1:0] side_i,
  output logic           vld_o,
  output logic [NW-1:0]  quot_o,
  output logic [DW-1:0]  rem_o,
  output logic [SBW-1:0] side_o
);

  logic [NW-1:0]  vld_r;
  logic [DW-1:0]  rem_r   [NW];
  logic [NW-1:0]  nq_r    [NW];
  logic [DW-1:0]  den_r   [NW];
  logic [SBW-1:0] side_r  [NW];

  logic [NW-1:0]  src_vld;
  logic [DW-1:0]  src_rem [NW];
  logic [NW-1:0]  src_nq  [NW];
  logic [DW-1:0]  src_den [NW];
  logic [SBW-1:0] src_side[NW];
  logic [DW-1:0]  rem_nxt [NW];
  logic [NW-1:0]  nq_nxt  [NW];

  // Each stage takes the previous stage's registers; stage zero takes the inputs.
  always_comb begin
    src_vld[0]  = vld_i;
    src_rem[0]  = '0;
    src_nq[0]   = num_i;
    src_den[0]  = den_i;
    src_side[0] = side_i;
    for (int i = 1; i < NW; i++) begin
      src_vld[i]  = vld_r[i-1];
      src_rem[i]  = rem_r[i-1];
      src_nq[i]   = nq_r[i-1];
      src_den[i]  = den_r[i-1];
      src_side[i] = side_r[i-1];
    end
  end

  // Shift in the next numerator bit and try one subtraction.
  always_comb begin
    logic [DW:0] trial;
    for (int i = 0; i < NW; i++) begin
      trial = {src_rem[i], src_nq[i][NW-1]};
      if (trial >= {1'b0, src_den[i]}) begin
        rem_nxt[i] = DW'(trial - {1'b0, src_den[i]});
        nq_nxt[i]  = {src_nq[i][NW-2:0], 1'b1};
      end else begin
        rem_nxt[i] = trial[DW-1:0];
        nq_nxt[i]  = {src_nq[i][NW-2:0], 1'b0};
      end
    end
  end

  // Valid bits are control state and clear at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= src_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NW; i++) begin
        rem_r[i]  <= rem_nxt[i];
        nq_r[i]   <= nq_nxt[i];
        den_r[i]  <= src_den[i];
        side_r[i] <= src_side[i];
      end
    end
  end

  assign vld_o  = vld_r[NW-1];
  assign quot_o = nq_r[NW-1];
  assign rem_o  = rem_r[NW-1];
  assign side_o = side_r[NW-1];

  // A finished remainder is always below its divisor.
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NW-1] |-> (rem_r[NW-1] < den_r[NW-1]))
    else $error("divider remainder not below divisor");

endmodule

>>> hdl/tgpb_key_map.sv
// Key-center map for the current and start positions and their semitone difference.
module tgpb_key_map #(
  parameter int unsigned X_BITS = 12,
  parameter int unsigned NMAG   = 18
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  tgpb_pkg::map_cfg_t         cfg,
  input  logic                       vld_i,
  input  logic [1:0][X_BITS:0]       q_i,
  input  logic [1:0][12:0]           r_i,
  input  logic [1:0]                 neg_i,
  input  logic signed [NMAG:0]       lin_i,
  output logic                       vld_o,
  output logic [NMAG-1:0]            mag_o,
  output logic                       neg_o
);
  import tgpb_pkg::*;

  localparam int unsigned OCTW = X_BITS + 2;
  localparam int unsigned POSW = NMAG;
  localparam int unsigned DIFW = NMAG + 1;

  logic [3:0] vld_r;

  logic signed [OCTW-1:0] oct_r   [2];
  logic [12:0]            rm_r    [2];
  logic signed [NMAG:0]   lin1_r, lin2_r, lin3_r;

  logic [3:0]             seg_r   [2];
  logic                   low_r   [2];
  logic [13:0]            rem2_r  [2];
  logic signed [POSW-1:0] octw_r  [2];

  logic signed [POSW-1:0] pos_r   [2];

  logic [NMAG-1:0]        mag_r;
  logic                   neg_r;

  logic signed [OCTW-1:0] oct_nxt [2];
  logic [12:0]            rm_nxt  [2];
  logic [3:0]             seg_nxt [2];
  logic                   low_nxt [2];
  logic signed [POSW-1:0] octw_nxt[2];
  logic signed [POSW-1:0] pos_nxt [2];
  logic [NMAG-1:0]        mag_nxt;
  logic                   neg_nxt;
  logic [12:0]            oct_px;

  assign oct_px = 13'(cfg.weff) * 13'd7;

  // Floor the octave toward minus infinity and fold the remainder up.
  always_comb begin
    logic signed [OCTW-1:0] qx;
    for (int l = 0; l < 2; l++) begin
      qx = $signed({1'b0, q_i[l]});
      if (neg_i[l] && r_i[l] != 13'd0) begin
        oct_nxt[l] = -(qx + OCTW'(1));
        rm_nxt[l]  = oct_px - r_i[l];
      end else if (neg_i[l]) begin
        oct_nxt[l] = -qx;
        rm_nxt[l]  = r_i[l];
      end else begin
        oct_nxt[l] = qx;
        rm_nxt[l]  = r_i[l];
      end
    end
  end

  // Find the segment by comparing against the key centers, and scale the octave.
  always_comb begin
    logic [13:0] rem2;
    logic [13:0] thr;
    logic [3:0]  cnt;
    logic signed [OCTW+16:0] prod;
    for (int l = 0; l < 2; l++) begin
      rem2 = {rm_r[l], 1'b0};
      cnt  = '0;
      for (int k = 1; k < 12; k++) begin
        thr = 14'(key_centre(4'(k))) * 14'(cfg.weff);
        cnt = cnt + 4'(rem2 >= thr);
      end
      seg_nxt[l]  = cnt;
      low_nxt[l]  = rem2 <= 14'(cfg.weff);
      prod        = oct_r[l] * $signed({2'b00, 15'(cfg.weff) * 15'd24});
      octw_nxt[l] = POSW'(prod);
    end
  end

  // Interpolate within the segment and add the octave offset.
  always_comb begin
    logic signed [16:0] s2w;
    logic signed [16:0] off;
    for (int l = 0; l < 2; l++) begin
      off = $signed({3'b000, rem2_r[l]})
          - $signed({3'b000, 14'(key_centre(seg_r[l])) * 14'(cfg.weff)});
      if (low_r[l]) begin
        s2w = ($signed({3'b000, rem2_r[l]}) - $signed({7'd0, cfg.weff})) <<< 1;
      end else if (seg_steep(seg_r[l])) begin
        s2w = $signed({1'b0, 15'(cfg.weff) * 15'(seg_r[l]), 1'b0}) + (off <<< 1);
      end else begin
        s2w = $signed({1'b0, 15'(cfg.weff) * 15'(seg_r[l]), 1'b0}) + off;
      end
      pos_nxt[l] = octw_r[l] + POSW'(s2w);
    end
  end

  // Pick the key-map difference or the linear value and split off the sign.
  always_comb begin
    logic signed [DIFW-1:0] num;
    if (!cfg.key_mode) begin
      num = DIFW'(lin3_r);
    end else if (cfg.wzero) begin
      num = '0;
    end else begin
      num = DIFW'(pos_r[0]) - DIFW'(pos_r[1]);
    end
    neg_nxt = num[DIFW-1];
    mag_nxt = num[DIFW-1] ? NMAG'(-num) : NMAG'(num);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        oct_r[l]  <= oct_nxt[l];
        rm_r[l]   <= rm_nxt[l];
        seg_r[l]  <= seg_nxt[l];
        low_r[l]  <= low_nxt[l];
        rem2_r[l] <= {rm_r[l], 1'b0};
        octw_r[l] <= octw_nxt[l];
        pos_r[l]  <= pos_nxt[l];
      end
      lin1_r <= lin_i;
      lin2_r <= lin1_r;
      lin3_r <= lin2_r;
      mag_r  <= mag_nxt;
      neg_r  <= neg_nxt;
    end
  end

  assign vld_o = vld_r[3];
  assign mag_o = mag_r;
  assign neg_o = neg_r;

endmodule

>>> hdl/touch_glide_pitch_bend_unit.sv
// Top level of the touch glide pitch-bend unit: configuration, dividers and output stage.
//
// A touch sample (start_x, delta_x) enters on the in_ channel and leaves as a
// 14-bit pitch-bend word on the out_ channel; 8192 is center, both ends saturate.
// A transfer happens on a clock edge with valid high and stall low.
// The unit is a fixed pipeline that takes one sample every cycle unless the
// output stalls; the three divider pipelines make up most of its depth, each
// giving one quotient bit per stage.
// When the receiver stalls while a result waits, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Configuration registers are written through cfg_we, cfg_idx and cfg_wdata and
// must change only while no sample is in flight.
// Synchronous reset clears all valid bits and loads mode 0 (key map), range 48,
// white-key width 64 and left edge 0.
module touch_glide_pitch_bend_unit #(
  parameter int unsigned X_BITS    = 12,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [tgpb_pkg::IDX_BITS-1:0]            cfg_idx,
  input  logic [((X_BITS > 10) ? X_BITS : 10)-1:0] cfg_wdata,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [X_BITS-1:0]                        in_start_x,
  input  logic signed [X_BITS:0]                   in_delta_x,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [tgpb_pkg::BEND_BITS-1:0]           out_bend_value
);
  import tgpb_pkg::*;

  localparam int unsigned CW   = (X_BITS > 10) ? X_BITS : 10;
  localparam int unsigned PMAG = (X_BITS + 4 > 17) ? X_BITS + 4 : 17;
  localparam int unsigned NMAG = PMAG + 1;
  localparam int unsigned NW1  = X_BITS + 1;
  localparam int unsigned NW2  = NMAG + FRAC_BITS;
  localparam int unsigned SH_N = (FRAC_BITS < 13) ? 13 - FRAC_BITS : 0;
  localparam int unsigned SH_D = (FRAC_BITS > 13) ? FRAC_BITS - 13 : 0;
  localparam int unsigned QCW  = FRAC_BITS + 6;
  localparam int unsigned NW3  = QCW + SH_N;
  localparam int unsigned DW3  = RANGE_BITS + SH_D;

  // Configuration registers.
  logic [MODE_BITS-1:0]  mode_r;
  logic [RANGE_BITS-1:0] range_r;
  logic [W_BITS-1:0]     width_r;
  logic [X_BITS-1:0]     left_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_KEY;
      range_r <= RANGE_BITS'(48);
      width_r <= W_BITS'(64);
      left_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_BEND_MODE:   mode_r  <= cfg_wdata[MODE_BITS-1:0];
        REG_BEND_RANGE:  range_r <= cfg_wdata[RANGE_BITS-1:0];
        REG_WHITE_WIDTH: width_r <= cfg_wdata[W_BITS-1:0];
        REG_LEFT_X:      left_r  <= cfg_wdata[X_BITS-1:0];
        default: ;
      endcase
    end
  end

  map_cfg_t              mcfg;
  logic [RANGE_BITS-1:0] rng;
  logic                  lin_mode;

  assign lin_mode      = (mode_r == MODE_SEMI) || (mode_r == MODE_WHOLE);
  assign mcfg.key_mode = !lin_mode;
  assign mcfg.wzero    = (width_r == '0);
  assign mcfg.weff     = (width_r == '0) ? W_BITS'(1) : width_r;
  assign rng           = (range_r == '0) ? RANGE_BITS'(1) : range_r;

  // The whole pipeline advances unless a finished result is held up.
  logic en;
  logic out_valid_r;
  logic [BEND_BITS-1:0] out_bend_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // Pixel offsets from the keyboard edge and the linear-mode numerator.
  logic signed [X_BITS+1:0] d_cur, d_st;
  logic [X_BITS:0]          dm_cur, dm_st;
  logic signed [NMAG:0]     lin_num;
  logic signed [NMAG:0]     dx_ext;

  always_comb begin
    d_cur   = $signed({2'b00, in_start_x}) + (X_BITS+2)'(in_delta_x)
            - $signed({2'b00, left_r});
    d_st    = $signed({2'b00, in_start_x}) - $signed({2'b00, left_r});
    dm_cur  = d_cur[X_BITS+1] ? NW1'(-d_cur) : NW1'(d_cur);
    dm_st   = d_st[X_BITS+1]  ? NW1'(-d_st)  : NW1'(d_st);
    dx_ext  = (NMAG+1)'(in_delta_x);
    lin_num = (mode_r == MODE_SEMI) ? (dx_ext <<< 1) : (dx_ext <<< 2);
  end

  // Octave division for both positions.
  logic                   v1;
  logic [1:0][X_BITS:0]   q1;
  logic [1:0][12:0]       r1;
  logic [1:0]             n1;
  logic signed [NMAG:0]   lin1;
  logic [12:0]            oct_px;

  assign oct_px = 13'(mcfg.weff) * 13'd7;

  tgpb_div #(.NW(NW1), .DW(13), .SBW(NMAG + 2)) u_div_cur (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_valid),
    .num_i  (dm_cur),
    .den_i  (oct_px),
    .side_i ({lin_num, d_cur[X_BITS+1]}),
    .vld_o  (v1),
    .quot_o (q1[0]),
    .rem_o  (r1[0]),
    .side_o ({lin1, n1[0]})
  );

  tgpb_div #(.NW(NW1), .DW(13), .SBW(1)) u_div_st (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_valid),
    .num_i  (dm_st),
    .den_i  (oct_px),
    .side_i (d_st[X_BITS+1]),
    .vld_o  (),
    .quot_o (q1[1]),
    .rem_o  (r1[1]),
    .side_o (n1[1])
  );

  // Semitone difference times twice the key width.
  logic            v2;
  logic [NMAG-1:0] mag2;
  logic            neg2;

  tgpb_key_map #(.X_BITS(X_BITS), .NMAG(NMAG)) u_key_map (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .cfg   (mcfg),
    .vld_i (v1),
    .q_i   (q1),
    .r_i   (r1),
    .neg_i (n1),
    .lin_i (lin1),
    .vld_o (v2),
    .mag_o (mag2),
    .neg_o (neg2)
  );

  // Bend in Q.FRAC_BITS semitones.
  logic           v3;
  logic [NW2-1:0] q2;
  logic           neg3;

  tgpb_div #(.NW(NW2), .DW(W_BITS + 1), .SBW(1)) u_div_semi (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (v2),
    .num_i  (NW2'(mag2) << FRAC_BITS),
    .den_i  ({mcfg.weff, 1'b0}),
    .side_i (neg2),
    .vld_o  (v3),
    .quot_o (q2),
    .rem_o  (),
    .side_o (neg3)
  );

  // Beyond 64 semitones every range saturates, so the bend is clamped there.
  logic [QCW-1:0] q2c;
  assign q2c = (q2[NW2-1:QCW] != '0) ? '1 : q2[QCW-1:0];

  // Pitch-bend offset: bend scaled by 8192 over the range.
  logic           v4;
  logic [NW3-1:0] q3;
  logic           neg4;

  tgpb_div #(.NW(NW3), .DW(DW3), .SBW(1)) u_div_range (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (v3),
    .num_i  (NW3'(q2c) << SH_N),
    .den_i  (DW3'(rng) << SH_D),
    .side_i (neg3),
    .vld_o  (v4),
    .quot_o (q3),
    .rem_o  (),
    .side_o (neg4)
  );

  // Center, saturate and hold the result until its transfer.
  logic                 sat;
  logic [BEND_BITS-1:0] bend_nxt;

  always_comb begin
    sat = (q3[NW3-1:13] != '0);
    if (neg4) begin
      bend_nxt = sat ? '0 : BEND_CENTRE - {1'b0, q3[12:0]};
    end else begin
      bend_nxt = sat ? BEND_MAX : BEND_CENTRE + {1'b0, q3[12:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_bend_r <= bend_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bend_value = out_bend_r;

  // A held result freezes the input side in the same cycle.
  a_hold_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> in_stall)
    else $error("input accepted while result is held");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");

  // A zero key width in key mode gives no bend at all.
  a_zero_width_key: assert property (@(posedge clk) disable iff (!rst_n)
    (v2 && mcfg.key_mode && mcfg.wzero) |-> (mag2 == '0))
    else $error("nonzero bend with zero key width");

endmodule

>>> verif/touch_glide_pitch_bend_checker.sv
// Checker for the glide pitch-bend unit: predicts each bend word and compares it.
`timescale 1ns / 1ps
module touch_glide_pitch_bend_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [11:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [11:0] in_start_x,
  input  logic [12:0] in_delta_x,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [13:0] out_bend_value,
  output int          fail_count,
  output int          pending
);
  import tgpb_pkg::*;

  // Key centers in half-white-key units, semitone 0 to 12.
  localparam longint CENTRE_HALF [13] = '{1, 2, 3, 4, 5, 7, 8, 9, 10, 11, 12, 13, 15};

  logic [1:0]  mode_q;
  logic [5:0]  range_q;
  logic [9:0]  width_q;
  logic [11:0] left_q;
  logic [13:0] bend_fifo[$];

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b != 0) && ((a < 0) != (b < 0))) q = q - 1;
    return q;
  endfunction

  // Semitone position of a pixel offset from the left edge, scaled by 2*w.
  function automatic longint semis_scaled(longint d, longint w);
    longint octave, rem, seg_step, s2w;
    int     s;
    octave = floor_quot(2 * d, 14 * w);
    rem    = 2 * d - octave * 14 * w;
    if (rem <= CENTRE_HALF[0] * w) begin
      s2w = 2 * (rem - CENTRE_HALF[0] * w);
    end else begin
      s = 0;
      while (s < 12 && rem >= CENTRE_HALF[s + 1] * w) s++;
      if (s > 11) s = 11;
      seg_step = 2 / (CENTRE_HALF[s + 1] - CENTRE_HALF[s]);
      s2w = longint'(s) * 2 * w + seg_step * (rem - CENTRE_HALF[s] * w);
    end
    return octave * 24 * w + s2w;
  endfunction

  function automatic logic [13:0] predict_bend(logic [11:0] sx, logic signed [12:0] dx);
    longint w, rng, num, den, bend_q, v;
    w   = longint'(width_q);
    rng = (range_q == 0) ? 1 : longint'(range_q);
    if (mode_q == MODE_SEMI || mode_q == MODE_WHOLE) begin
      if (w == 0) w = 1;
      den = 2 * w;
      num = ((mode_q == MODE_SEMI) ? 2 : 4) * longint'(dx);
    end else if (w == 0) begin
      den = 1;
      num = 0;
    end else begin
      den = 2 * w;
      num = semis_scaled(longint'(sx) + longint'(dx) - longint'(left_q), w)
          - semis_scaled(longint'(sx) - longint'(left_q), w);
    end
    bend_q = (num * 65536) / den;
    v = 8192 + (bend_q * 8192) / (rng * 65536);
    if (v < 0) v = 0;
    if (v > 16383) v = 16383;
    return v[13:0];
  endfunction

  assign pending = bend_fifo.size();

  // Track configuration, queue predictions on input transfers, check outputs.
  always @(posedge clk) begin
    logic [13:0] want;
    if (!rst_n) begin
      mode_q  <= MODE_KEY;
      range_q <= 6'd48;
      width_q <= 10'd64;
      left_q  <= 12'd0;
      bend_fifo.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_BEND_MODE:   mode_q  <= cfg_wdata[1:0];
          REG_BEND_RANGE:  range_q <= cfg_wdata[5:0];
          REG_WHITE_WIDTH: width_q <= cfg_wdata[9:0];
          default:         left_q  <= cfg_wdata;
        endcase
      end
      if (in_valid && !in_stall)
        bend_fifo.push_back(predict_bend(in_start_x, $signed(in_delta_x)));
      if (out_valid && !out_stall) begin
        if (bend_fifo.size() == 0) begin
          $error("bend_value: unexpected transfer, actual %0d", out_bend_value);
          fail_count <= fail_count + 1;
        end else begin
          want = bend_fifo.pop_front();
          if (want !== out_bend_value) begin
            $error("bend_value: expected %0d, actual %0d", want, out_bend_value);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> verif/touch_glide_pitch_bend_unit_tb.sv
// Testbench top: stimulus, configuration phases and verdict for the glide pitch-bend unit.
`timescale 1ns / 1ps
module touch_glide_pitch_bend_unit_tb;
  import tgpb_pkg::*;

  typedef struct {
    int mode;
    int range;
    int width;
    int left;
  } bend_cfg_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = REG_BEND_MODE;
  logic [11:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] in_start_x = '0;
  logic signed [12:0] in_delta_x = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [13:0] out_bend_value;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  always #1 clk = ~clk;

  touch_glide_pitch_bend_unit u_dut (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_wdata,
    .in_valid, .in_stall, .in_start_x, .in_delta_x,
    .out_valid, .out_stall, .out_bend_value
  );

  touch_glide_pitch_bend_checker u_chk (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_wdata,
    .in_valid, .in_stall, .in_start_x, .in_delta_x,
    .out_valid, .out_stall, .out_bend_value,
    .fail_count, .pending
  );

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold when asked, none when calm.
  initial begin
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Offer one sample, with an optional gap before it, and wait for its transfer.
  task automatic send_sample(logic [11:0] sx, logic signed [12:0] dx);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_start_x <= sx;
    in_delta_x <= dx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Registers change only once the pipeline has drained.
  task automatic load_cfg(bend_cfg_t c);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= REG_BEND_MODE;   cfg_wdata <= 12'(c.mode);  @(posedge clk);
    cfg_idx <= REG_BEND_RANGE;  cfg_wdata <= 12'(c.range); @(posedge clk);
    cfg_idx <= REG_WHITE_WIDTH; cfg_wdata <= 12'(c.width); @(posedge clk);
    cfg_idx <= REG_LEFT_X;      cfg_wdata <= 12'(c.left);  @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly short glides, sometimes anywhere in the field's range.
  task automatic send_random(int n);
    logic [11:0] sx;
    logic signed [12:0] dx;
    repeat (n) begin
      sx = 12'($urandom);
      if ($urandom_range(0, 2) == 0) dx = 13'($urandom);
      else dx = 13'($signed($urandom_range(0, 600)) - 300);
      send_sample(sx, dx);
    end
  endtask

  bend_cfg_t phases[$];
  bend_cfg_t c;

  initial begin
    phases = '{
      '{0, 48, 64, 0}, '{0, 1, 1023, 4095}, '{0, 63, 1, 100}, '{0, 12, 0, 0},
      '{1, 2, 0, 7}, '{1, 48, 1023, 0}, '{2, 0, 37, 4095}, '{2, 24, 64, 0},
      '{3, 5, 80, 200}, '{0, 2, 48, 1000}
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed samples at reset settings: field extremes and centered glides.
    send_sample(12'd0, 13'sd0);
    send_sample(12'd4095, 13'sd0);
    send_sample(12'd0, -13'sd4096);
    send_sample(12'd0, 13'sd4095);
    send_sample(12'd4095, -13'sd4096);
    send_sample(12'd4095, 13'sd4095);
    send_sample(12'd64, 13'sd32);
    send_sample(12'd32, -13'sd32);
    send_sample(12'd100, 13'sd1);
    send_sample(12'd100, -13'sd1);

    // Configuration phases, including the extremes of every register.
    foreach (phases[i]) begin
      load_cfg(phases[i]);
      if (i == 1) hold_req = 1'b1;
      send_random(150);
    end
    repeat (3) begin
      c.mode  = $urandom_range(0, 3);
      c.range = $urandom_range(0, 63);
      c.width = $urandom_range(1, 200);
      c.left  = $urandom_range(0, 4095);
      load_cfg(c);
      send_random(120);
    end

    // Final stretch with no idling on either side.
    calm = 1'b1;
    send_random(150);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
